FILE: hw/rtl/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

  // Default sizing of the descriptor table and of block offsets.
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] POOL_SIZE_RESET = 32'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE = 2'd1;

  // Request opcodes.
  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] block_address;
  } ffba_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   address;
  } ffba_rsp_t;

  // Datapath operations, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_STEP,
    OP_SAVE_B2,
    OP_SPLIT1,
    OP_SPLIT2,
    OP_SPLIT2_LAST,
    OP_CLR_FREE,
    OP_MERGE,
    OP_PUSH_B2,
    OP_RES
  } ffba_op_e;

  typedef struct packed {
    ffba_op_e            op;
    logic [STATUS_W-1:0] status;
    logic                res_addr;
  } ffba_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic size_zero;
    logic fit_ge;
    logic fit_gt;
    logic cnt_zero;
    logic is_tail;
    logic steps_max;
    logic addr_match;
    logic join_prev;
    logic join_next;
  } ffba_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ffba_datapath.sv
`default_nettype none

module ffba_datapath import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ffba_req_t            req_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_wdata_i,
  input  wire ffba_cmd_t            cmd_i,
  output ffba_sts_t                 sts_o,
  output ffba_rsp_t                 rsp_o,
  output logic                      done_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(MAX_BLOCKS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_BLOCKS);

  // Descriptor memories and the spare descriptor stack.
  logic [ADDR_BITS-1:0] start_mem [MAX_BLOCKS];
  logic [DATA_W-1:0]    free_mem  [MAX_BLOCKS];
  logic [IDX_W-1:0]     link_mem  [MAX_BLOCKS];
  logic [IDX_W-1:0]     spare_mem [MAX_BLOCKS];

  // Configuration and allocator control state.
  logic [DATA_W-1:0] base_q, psize_q;
  logic [IDX_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, wm_q, wm_d;
  logic              init_s_q, init_f_q, init_l_q;

  // Request and walk registers.
  ffba_req_t            req_q;
  logic [IDX_W-1:0]     c_q, b1_q, b2_q, n_q;
  logic [CNT_W-1:0]     steps_q;
  logic [DATA_W-1:0]    pf_q;
  logic [ADDR_BITS-1:0] s2_q;

  // Registered read data.
  logic [ADDR_BITS-1:0] st_rd_q;
  logic [DATA_W-1:0]    fr_rd_q;
  logic [IDX_W-1:0]     lk_rd_q, sp_rd_q;
  logic                 byp_s_q, byp_f_q, byp_l_q;
  logic [ADDR_BITS-1:0] rs;
  logic [DATA_W-1:0]    rf;
  logic [IDX_W-1:0]     rl;

  ffba_rsp_t rsp_q;
  logic      done_q;

  // Read port control.
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] pop_idx;

  // Write port control.
  logic                 st_we, fr_we, lk_we, sp_we;
  logic [IDX_W-1:0]     st_wa, fr_wa, lk_wa, sp_wa;
  logic [ADDR_BITS-1:0] st_wd;
  logic [DATA_W-1:0]    fr_wd;
  logic [IDX_W-1:0]     lk_wd, sp_wd;
  logic [DATA_W-1:0]    f2;
  logic                 join_prev, join_next;

  assign rs = byp_s_q ? '0 : st_rd_q;
  assign rf = byp_f_q ? psize_q : fr_rd_q;
  assign rl = byp_l_q ? '0 : lk_rd_q;

  // The stack holds its initial contents below the low-water mark.
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign pop_idx = (cnt_m1 < wm_q) ? cnt_q[IDX_W-1:0] : sp_rd_q;

  assign f2        = DATA_W'(rs - s2_q);
  assign join_prev = (pf_q != '0) && (b1_q != last_q);
  assign join_next = (rf != '0) || (c_q == last_q);

  // Status toward the controller.
  always_comb begin
    sts_o.is_alloc   = (req_q.opcode == OPC_ALLOC);
    sts_o.size_zero  = (req_q.request_size == '0);
    sts_o.fit_ge     = (rf >= req_q.request_size);
    sts_o.fit_gt     = (rf > req_q.request_size);
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.is_tail    = (c_q == last_q);
    sts_o.steps_max  = (steps_q == CNT_MAX);
    sts_o.addr_match = ((base_q + DATA_W'(rs)) == req_q.block_address);
    sts_o.join_prev  = join_prev;
    sts_o.join_next  = join_next;
  end

  // Read address selection.
  always_comb begin
    rd_en = 1'b0;
    raddr = rl;
    case (cmd_i.op)
      OP_LOAD: begin
        rd_en = 1'b1;
        raddr = last_q;
      end
      OP_FIRST, OP_STEP, OP_SAVE_B2: begin
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Descriptor reads; entry 0, while still at its reset value, is bypassed.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      st_rd_q <= start_mem[raddr];
      fr_rd_q <= free_mem[raddr];
      lk_rd_q <= link_mem[raddr];
      byp_s_q <= init_s_q && (raddr == '0);
      byp_f_q <= init_f_q && (raddr == '0);
      byp_l_q <= init_l_q && (raddr == '0);
    end
    if (cmd_i.op == OP_LOAD) begin
      sp_rd_q <= spare_mem[cnt_m1[IDX_W-1:0]];
    end
  end

  // Write port selection for each memory.
  always_comb begin
    st_we = 1'b0;
    st_wa = pop_idx;
    st_wd = rs + ADDR_BITS'(req_q.request_size);
    fr_we = 1'b0;
    fr_wa = c_q;
    fr_wd = '0;
    lk_we = 1'b0;
    lk_wa = c_q;
    lk_wd = rl;
    sp_we = 1'b0;
    sp_wa = cnt_q[IDX_W-1:0];
    sp_wd = c_q;
    case (cmd_i.op)
      OP_SPLIT1: begin
        st_we = 1'b1;
        fr_we = 1'b1;
        fr_wa = pop_idx;
        fr_wd = rf - req_q.request_size;
        lk_we = 1'b1;
        lk_wa = pop_idx;
        lk_wd = rl;
      end
      OP_SPLIT2, OP_SPLIT2_LAST: begin
        fr_we = 1'b1;
        lk_we = 1'b1;
        lk_wd = n_q;
      end
      OP_CLR_FREE: begin
        fr_we = 1'b1;
      end
      OP_MERGE: begin
        fr_we = 1'b1;
        sp_we = (join_prev || join_next) && (cnt_q < CNT_MAX);
        if (join_prev && join_next) begin
          fr_wa = b1_q;
          fr_wd = pf_q + rf + f2;
          lk_we = 1'b1;
          lk_wa = b1_q;
          lk_wd = rl;
        end else if (join_prev) begin
          fr_wa = b1_q;
          fr_wd = pf_q + f2;
          lk_we = 1'b1;
          lk_wa = b1_q;
          lk_wd = c_q;
          sp_wd = b2_q;
        end else if (join_next) begin
          fr_wa = b2_q;
          fr_wd = f2 + rf;
          lk_we = 1'b1;
          lk_wa = b2_q;
          lk_wd = rl;
        end else begin
          fr_wa = b2_q;
          fr_wd = f2;
        end
      end
      OP_PUSH_B2: begin
        sp_we = (cnt_q < CNT_MAX);
        sp_wd = b2_q;
      end
      default: begin
        st_we = 1'b0;
      end
    endcase
  end

  // Memory write ports.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      start_mem[st_wa] <= st_wd;
    end
    if (fr_we) begin
      free_mem[fr_wa] <= fr_wd;
    end
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    if (sp_we) begin
      spare_mem[sp_wa] <= sp_wd;
    end
  end

  // Next values of the last block, the spare count and its low-water mark.
  always_comb begin
    last_d = last_q;
    cnt_d  = cnt_q;
    wm_d   = wm_q;
    case (cmd_i.op)
      OP_SPLIT1: begin
        cnt_d = cnt_m1;
        if (cnt_m1 < wm_q) begin
          wm_d = cnt_m1;
        end
      end
      OP_SPLIT2_LAST: begin
        last_d = n_q;
      end
      OP_MERGE: begin
        if (sp_we) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
        if (join_next && (c_q == last_q)) begin
          last_d = join_prev ? b1_q : b2_q;
        end
      end
      OP_PUSH_B2: begin
        if (sp_we) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Control state; a pool size write restarts the allocator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      psize_q  <= POOL_SIZE_RESET;
      last_q   <= '0;
      cnt_q    <= CNT_INIT;
      wm_q     <= CNT_INIT;
      init_s_q <= 1'b1;
      init_f_q <= 1'b1;
      init_l_q <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == OP_RES);
      if (cfg_we_i && (cfg_index_i == REG_POOL_BASE)) begin
        base_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_POOL_SIZE)) begin
        psize_q  <= cfg_wdata_i;
        last_q   <= '0;
        cnt_q    <= CNT_INIT;
        wm_q     <= CNT_INIT;
        init_s_q <= 1'b1;
        init_f_q <= 1'b1;
        init_l_q <= 1'b1;
      end else begin
        last_q <= last_d;
        cnt_q  <= cnt_d;
        wm_q   <= wm_d;
        if (st_we && (st_wa == '0)) begin
          init_s_q <= 1'b0;
        end
        if (fr_we && (fr_wa == '0)) begin
          init_f_q <= 1'b0;
        end
        if (lk_we && (lk_wa == '0)) begin
          init_l_q <= 1'b0;
        end
      end
    end
  end

  // Request capture, walk cursor and saved block values.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        req_q <= req_i;
        c_q   <= last_q;
      end
      OP_FIRST, OP_STEP: begin
        pf_q    <= rf;
        b1_q    <= c_q;
        c_q     <= rl;
        steps_q <= (cmd_i.op == OP_FIRST) ? '0 : steps_q + CNT_W'(1);
      end
      OP_SAVE_B2: begin
        s2_q <= rs;
        b2_q <= c_q;
        c_q  <= rl;
      end
      OP_SPLIT1: begin
        n_q <= pop_idx;
      end
      default: begin
        n_q <= n_q;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RES) begin
      rsp_q.status  <= cmd_i.status;
      rsp_q.address <= cmd_i.res_addr ? (base_q + DATA_W'(rs)) : '0;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX) else $error("spare count beyond table size");
  a_wm_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wm_q <= cnt_q) else $error("low-water mark above spare count");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SPLIT1) && !cfg_we_i |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("split did not take one spare descriptor");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ffba_ctrl.sv
`default_nettype none

module ffba_ctrl import ffba_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire ffba_sts_t sts_i,
  output ffba_cmd_t      cmd_o,
  output logic           busy_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HEAD   = 4'd1;
  localparam logic [3:0] S_AWALK  = 4'd2;
  localparam logic [3:0] S_SPLIT1 = 4'd3;
  localparam logic [3:0] S_SPLIT2 = 4'd4;
  localparam logic [3:0] S_CLRF   = 4'd5;
  localparam logic [3:0] S_FWALK  = 4'd6;
  localparam logic [3:0] S_MERGE  = 4'd7;
  localparam logic [3:0] S_PUSH   = 4'd8;
  localparam logic [3:0] S_RES    = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                res_addr_q, res_addr_d;
  logic                split_last_q, split_last_d;

  // Sequencer: one datapath operation per cycle.
  always_comb begin
    state_d         = state_q;
    status_d        = status_q;
    res_addr_d      = res_addr_q;
    split_last_d    = split_last_q;
    cmd_o.op        = OP_NONE;
    cmd_o.status    = status_q;
    cmd_o.res_addr  = res_addr_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op   = OP_LOAD;
          res_addr_d = 1'b0;
          state_d    = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!sts_i.is_alloc) begin
          cmd_o.op = OP_FIRST;
          state_d  = S_FWALK;
        end else if (sts_i.size_zero) begin
          status_d = ST_ZERO_SIZE;
          state_d  = S_RES;
        end else if (sts_i.fit_ge) begin
          if (sts_i.cnt_zero) begin
            status_d = ST_TABLE_FULL;
            state_d  = S_RES;
          end else begin
            split_last_d = 1'b1;
            state_d      = S_SPLIT1;
          end
        end else begin
          cmd_o.op = OP_FIRST;
          state_d  = S_AWALK;
        end
      end
      S_AWALK: begin
        if (sts_i.fit_ge) begin
          if (!sts_i.fit_gt) begin
            state_d = S_CLRF;
          end else if (sts_i.cnt_zero) begin
            status_d = ST_TABLE_FULL;
            state_d  = S_RES;
          end else begin
            split_last_d = 1'b0;
            state_d      = S_SPLIT1;
          end
        end else if (sts_i.is_tail || sts_i.steps_max) begin
          status_d = ST_NO_FIT;
          state_d  = S_RES;
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_SPLIT1: begin
        cmd_o.op = OP_SPLIT1;
        state_d  = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd_o.op   = split_last_q ? OP_SPLIT2_LAST : OP_SPLIT2;
        status_d   = ST_OK;
        res_addr_d = 1'b1;
        state_d    = S_RES;
      end
      S_CLRF: begin
        cmd_o.op   = OP_CLR_FREE;
        status_d   = ST_OK;
        res_addr_d = 1'b1;
        state_d    = S_RES;
      end
      S_FWALK: begin
        if (sts_i.steps_max || sts_i.addr_match || sts_i.is_tail) begin
          if (sts_i.is_tail || !sts_i.addr_match) begin
            status_d = ST_NOT_FOUND;
            state_d  = S_RES;
          end else begin
            cmd_o.op = OP_SAVE_B2;
            state_d  = S_MERGE;
          end
        end else begin
          cmd_o.op = OP_STEP;
        end
      end
      S_MERGE: begin
        cmd_o.op = OP_MERGE;
        status_d = ST_OK;
        state_d  = (sts_i.join_prev && sts_i.join_next) ? S_PUSH : S_RES;
      end
      S_PUSH: begin
        cmd_o.op = OP_PUSH_B2;
        state_d  = S_RES;
      end
      S_RES: begin
        cmd_o.op = OP_RES;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      status_q     <= ST_OK;
      res_addr_q   <= 1'b0;
      split_last_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      status_q     <= status_d;
      res_addr_q   <= res_addr_d;
      split_last_q <= split_last_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_res_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES) |=> (state_q == S_IDLE))
    else $error("result transfer did not end the request");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |-> !busy_o)
    else $error("request loaded while busy");
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |=> busy_o)
    else $error("accepted request did not raise busy");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/first_fit_block_allocator_unit.sv
`default_nettype none

// First-fit block allocator. A request is taken when start_i is high and
// busy_o is low; its single result appears on rsp_o, with done_o high for
// exactly one cycle, and the receiver cannot stall it. An allocate or free
// walks the descriptor list one block per cycle, and the time a request
// takes is set by that list walk through the descriptor memories plus the
// split or merge updates. Writes to pool_size reinitialize the pool at
// once, with no clearing pass.
module first_fit_block_allocator_unit import ffba_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire ffba_req_t            req_i,
  output logic                      busy_o,
  output logic                      done_o,
  output ffba_rsp_t                 rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_wdata_i
);

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  // Sequencer.
  ffba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Descriptor memories and arithmetic.
  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .done_o      (done_o)
  );

endmodule

`default_nettype wire
